/* design/assert_macros.svh */
// Assertion macros shared by the jsu_queue and jsu_back design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* design/jsu_pkg.sv */
package jsu_pkg;

   typedef enum logic [2:0] {
      MODE_WAIT = 3'd0,
      MODE_BODY = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX1 = 3'd3,
      MODE_HEX2 = 3'd4,
      MODE_HEX3 = 3'd5,
      MODE_HEX4 = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_END     = 2'd1,
      KIND_EOI_ERR = 2'd2,
      KIND_HEX_ERR = 2'd3
   } kind_type;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;

   localparam logic [7:0] CTRL_BS = 8'h08;
   localparam logic [7:0] CTRL_FF = 8'h0c;
   localparam logic [7:0] CTRL_LF = 8'h0a;
   localparam logic [7:0] CTRL_CR = 8'h0d;
   localparam logic [7:0] CTRL_HT = 8'h09;

   localparam logic [15:0] UTF8_ONE_MAX = 16'h007f;
   localparam logic [15:0] UTF8_TWO_MAX = 16'h07ff;
   localparam logic [7:0]  UTF8_LEAD2   = 8'hc0;
   localparam logic [7:0]  UTF8_LEAD3   = 8'he0;
   localparam logic [7:0]  UTF8_CONT    = 8'h80;

   // One command holds every result that a single input byte causes.
   typedef struct packed {
      logic [1:0] count;
      kind_type   kind;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } cmd_type;

   // Returns {valid, digit} for one ASCII hex character.
   function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
      logic [4:0] result;
      result = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         result = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         result = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         result = {1'b1, 4'(c - 8'h37)};
      end
      return result;
   endfunction

endpackage

/* design/json_string_unescape_core.sv */
// JSON string unescaper. The request side is a queue write port: present one
// raw byte of JSON text on req_in_byte, or set req_end_of_input, and raise
// req_push; the transaction is taken at a clock edge where req_full is low.
// The response side is a queue read port: while rsp_empty is low the oldest
// result sits on rsp_kind, rsp_out_byte and rsp_last, and raising rsp_pop
// takes it. rsp_last marks the final result caused by one request byte.
// A request byte is decoded in the cycle it is taken; its command is registered
// in the command queue and then in the output stage, which drives the response
// ports. One request byte is taken every cycle while req_full is low; a byte can
// cause up to three results, which leave at one per cycle while rsp_pop is high.
// Between the decoder and the output stage sits a command queue of DEPTH
// entries, one entry per request byte that causes any result. While the
// receiver stalls, requests are still taken until that queue fills, and then
// req_full rises. Synchronous reset empties the queue and the output stage at
// once and puts the decoder back to waiting for any byte to open a string.
module json_string_unescape_core #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import jsu_pkg::*;

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_wdata;
   cmd_type q_rdata;

   jsu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .req_full         (req_full),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_wdata)
   );

   jsu_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

/* design/jsu_front.sv */
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_in_byte,
   input  logic             req_end_of_input,
   output logic             req_full,
   input  logic             q_full,
   output logic             q_push,
   output jsu_pkg::cmd_type q_data
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [11:0] cp_ff, cp_in;
   logic        accept;
   logic [4:0]  hex;
   logic        hex_ok;
   logic [15:0] cp;
   cmd_type     cmd;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign hex      = hex_digit_of(req_in_byte);
   assign hex_ok   = hex[4] && !req_end_of_input;
   assign cp       = {cp_ff, hex[3:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_WAIT;
         cp_ff   <= 12'd0;
      end else begin
         mode_ff <= mode_in;
         cp_ff   <= cp_in;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      cp_in   = cp_ff;
      if (accept) begin
         case (mode_ff)
            MODE_BODY: begin
               if (req_end_of_input || req_in_byte == CHAR_QUOTE) begin
                  mode_in = MODE_WAIT;
               end else if (req_in_byte == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end
            end
            MODE_ESC: begin
               if (req_end_of_input) begin
                  mode_in = MODE_WAIT;
               end else if (req_in_byte == CHAR_U) begin
                  mode_in = MODE_HEX1;
                  cp_in   = 12'd0;
               end else begin
                  mode_in = MODE_BODY;
               end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
               if (!hex_ok) begin
                  mode_in = MODE_WAIT;
                  cp_in   = 12'd0;
               end else begin
                  cp_in = {cp_ff[7:0], hex[3:0]};
                  case (mode_ff)
                     MODE_HEX1: mode_in = MODE_HEX2;
                     MODE_HEX2: mode_in = MODE_HEX3;
                     default:   mode_in = MODE_HEX4;
                  endcase
               end
            end
            MODE_HEX4: begin
               cp_in   = 12'd0;
               mode_in = hex_ok ? MODE_BODY : MODE_WAIT;
            end
            default: begin
               if (!req_end_of_input) begin
                  mode_in = MODE_BODY;
               end else begin
                  mode_in = MODE_WAIT;
               end
            end
         endcase
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.kind  = KIND_DATA;
      case (mode_ff)
         MODE_BODY: begin
            cmd.count = 2'd1;
            if (req_end_of_input) begin
               cmd.kind = KIND_EOI_ERR;
            end else if (req_in_byte == CHAR_QUOTE) begin
               cmd.kind = KIND_END;
            end else if (req_in_byte == CHAR_BACKSLASH) begin
               cmd.count = 2'd0;
            end else begin
               cmd.byte0 = req_in_byte;
            end
         end
         MODE_ESC: begin
            cmd.count = 2'd1;
            if (req_end_of_input) begin
               cmd.kind = KIND_EOI_ERR;
            end else begin
               case (req_in_byte)
                  CHAR_B:  cmd.byte0 = CTRL_BS;
                  CHAR_F:  cmd.byte0 = CTRL_FF;
                  CHAR_N:  cmd.byte0 = CTRL_LF;
                  CHAR_R:  cmd.byte0 = CTRL_CR;
                  CHAR_T:  cmd.byte0 = CTRL_HT;
                  CHAR_U:  cmd.count = 2'd0;
                  default: cmd.byte0 = req_in_byte;
               endcase
            end
         end
         MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
            if (!hex_ok) begin
               cmd.count = 2'd1;
               cmd.kind  = KIND_HEX_ERR;
            end
         end
         MODE_HEX4: begin
            if (!hex_ok) begin
               cmd.count = 2'd1;
               cmd.kind  = KIND_HEX_ERR;
            end else if (cp <= UTF8_ONE_MAX) begin
               cmd.count = 2'd1;
               cmd.byte0 = cp[7:0];
            end else if (cp <= UTF8_TWO_MAX) begin
               cmd.count = 2'd2;
               cmd.byte0 = UTF8_LEAD2 | {3'd0, cp[10:6]};
               cmd.byte1 = UTF8_CONT | {2'd0, cp[5:0]};
            end else begin
               cmd.count = 2'd3;
               cmd.byte0 = UTF8_LEAD3 | {4'd0, cp[15:12]};
               cmd.byte1 = UTF8_CONT | {2'd0, cp[11:6]};
               cmd.byte2 = UTF8_CONT | {2'd0, cp[5:0]};
            end
         end
         default: begin
            cmd.count = 2'd0;
         end
      endcase
   end

   assign q_push = accept && (cmd.count != 2'd0);
   assign q_data = cmd;

endmodule

/* design/jsu_queue.sv */
`include "assert_macros.svh"

module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output jsu_pkg::cmd_type pop_data
);
   import jsu_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && !valid)
   `ASSERT_ALWAYS(a_count_up, clock, reset, push && !pop |=> count_ff == $past(count_ff) + 1'b1)

endmodule

/* design/jsu_back.sv */
`include "assert_macros.svh"

module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  jsu_pkg::cmd_type q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);
   import jsu_pkg::*;

   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   cmd_type    cur_ff, cur_in;
   logic       is_last;
   logic       load;

   assign is_last = (idx_ff == cur_ff.count - 2'd1);
   assign load    = q_valid && (!busy_ff || (rsp_pop && is_last));
   assign q_pop   = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
         cur_in  = q_data;
      end else if (busy_ff && rsp_pop) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_out_byte = cur_ff.byte0;
         2'd1:    rsp_out_byte = cur_ff.byte1;
         default: rsp_out_byte = cur_ff.byte2;
      endcase
   end

   assign rsp_empty = !busy_ff;
   assign rsp_kind  = cur_ff.kind;
   assign rsp_last  = is_last;

   `ASSERT_ALWAYS(a_idx_in_range, clock, reset, !busy_ff || idx_ff < cur_ff.count)
   `ASSERT_ALWAYS(a_status_single, clock, reset, !busy_ff || cur_ff.kind == KIND_DATA || cur_ff.count == 2'd1)
   `ASSERT_ALWAYS(a_stall_holds, clock, reset, busy_ff && !rsp_pop |=> busy_ff && $stable(idx_ff))

endmodule
